>>> sv/grid_gradient_magnitude_macros.svh
// Assertion macros for the gradient magnitude block.
// Used by the port checker; no other dependencies.
`ifndef GRID_GRADIENT_MAGNITUDE_MACROS_SVH
`define GRID_GRADIENT_MAGNITUDE_MACROS_SVH

// Check an implication on every clock, quiet during reset.
`define GGM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after an antecedent, quiet during reset.
`define GGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check a condition in the cycle after an antecedent, also across reset.
`define GGM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ggm_pkg.sv
// Types and constants shared by the gradient magnitude block.
// No dependencies.
package ggm_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int POS_W     = 10;
  localparam int SIZE_W    = 11;
  localparam int NORM_W    = 48;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int DERIV_W   = PROD_W - 24;
  localparam int HALF_W    = DERIV_W / 2;
  localparam int SQ_W      = 2 * DERIV_W;
  localparam int SUM_W     = SQ_W + 2;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_SIZE     = 3'd0,
    REG_Y_SIZE     = 3'd1,
    REG_Z_SIZE     = 3'd2,
    REG_INV_STEP_X = 3'd3,
    REG_INV_STEP_Y = 3'd4,
    REG_INV_STEP_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] center_sample;
    logic [SAMPLE_W-1:0] x_prev_sample;
    logic [SAMPLE_W-1:0] x_next_sample;
    logic [SAMPLE_W-1:0] y_prev_sample;
    logic [SAMPLE_W-1:0] y_next_sample;
    logic [SAMPLE_W-1:0] z_prev_sample;
    logic [SAMPLE_W-1:0] z_next_sample;
    logic [POS_W-1:0]    x_pos;
    logic [POS_W-1:0]    y_pos;
    logic [POS_W-1:0]    z_pos;
  } in_t;

  typedef struct packed {
    logic [NORM_W-1:0] gradient_norm;
    logic              saturated;
  } out_t;

endpackage

>>> sv/ggm_sqrt_pipe.sv
// Pipelined integer square root, one result bit per register stage.
// Imports ggm_pkg; the default widths are literal values.
module ggm_sqrt_pipe #(
  parameter int RAD_W  = 82,
  parameter int ROOT_W = 41
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root
);
  import ggm_pkg::*;

  localparam int REM_W = ROOT_W + 3;

  logic              valid_r [0:ROOT_W];
  logic [RAD_W-1:0]  rad_r   [0:ROOT_W];
  logic [REM_W-1:0]  rem_r   [0:ROOT_W];
  logic [ROOT_W-1:0] root_r  [0:ROOT_W];

  // Stage zero is the incoming beat itself
  assign valid_r[0] = in_valid;
  assign rad_r[0]   = in_rad;
  assign rem_r[0]   = '0;
  assign root_r[0]  = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      rem_sh = {rem_r[k][REM_W-3:0], rad_r[k][RAD_W-1 -: 2]};
      trial  = {1'b0, root_r[k], 2'b01};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[k][ROOT_W-2:0], 1'b0};
      end
    end

    // Advance valid with the data
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= valid_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1]  <= {rad_r[k][RAD_W-3:0], 2'b00};
        rem_r[k+1]  <= rem_nxt;
        root_r[k+1] <= root_nxt;
      end
    end
  end

  assign out_valid = valid_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];

endmodule

>>> sv/grid_gradient_magnitude.sv
// Gradient magnitude of a 3-D grid point by finite differences.
// Depends on ggm_pkg and ggm_sqrt_pipe.
//
// Usage:
//   in_valid/in_stall/in_data carry one grid point per beat: the center
//   sample, its six axis neighbors and the point's coordinates.
//   out_valid/out_stall/out_data return one beat per point, in order:
//   the Q24.24 magnitude and a saturation flag.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the axis sizes and the
//   reciprocal spacings; cfg_ready is always high. Write only while idle.
// Throughput: one point per cycle unless the output stalls. Pipeline: five
//   arithmetic stages (edge select, scale multiply, split squaring, two
//   adds), then one square root stage per result bit.
// Stall: the whole pipeline holds while a valid result is stalled at the
//   output; in_stall then goes high in the same cycle and nothing is lost.
// Reset: clears all valid bits and loads sizes 2 and spacings 1.0.
module grid_gradient_magnitude #(
  parameter int GRID_MAX = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ggm_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ggm_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ggm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ggm_pkg::SAMPLE_W-1:0]        cfg_data
);
  import ggm_pkg::*;

  localparam logic [SAMPLE_W-1:0] ONE_Q824 = SAMPLE_W'(1 << 24);

  logic en;
  logic [SIZE_W-1:0]   size_r [3];
  logic [SAMPLE_W-1:0] inv_r  [3];

  // Pipeline moves unless a result is held at the output
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        size_r[a] <= SIZE_W'(2);
        inv_r[a]  <= ONE_Q824;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_X_SIZE:     size_r[0] <= cfg_data[SIZE_W-1:0];
        REG_Y_SIZE:     size_r[1] <= cfg_data[SIZE_W-1:0];
        REG_Z_SIZE:     size_r[2] <= cfg_data[SIZE_W-1:0];
        REG_INV_STEP_X: inv_r[0]  <= cfg_data;
        REG_INV_STEP_Y: inv_r[1]  <= cfg_data;
        REG_INV_STEP_Z: inv_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage 1: pick the difference rule per axis and take its magnitude
  logic [SAMPLE_W-1:0] prv [3];
  logic [SAMPLE_W-1:0] nxt [3];
  logic [POS_W-1:0]    pos [3];
  logic [SAMPLE_W-1:0] mag_nxt [3];
  logic                half_nxt [3];

  assign prv[0] = in_data.x_prev_sample;
  assign prv[1] = in_data.y_prev_sample;
  assign prv[2] = in_data.z_prev_sample;
  assign nxt[0] = in_data.x_next_sample;
  assign nxt[1] = in_data.y_next_sample;
  assign nxt[2] = in_data.z_next_sample;
  assign pos[0] = in_data.x_pos;
  assign pos[1] = in_data.y_pos;
  assign pos[2] = in_data.z_pos;

  always_comb begin
    logic [31:0]         n;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] lo;
    for (int a = 0; a < 3; a++) begin
      n = (32'(size_r[a]) > 32'(GRID_MAX)) ? 32'(GRID_MAX) : 32'(size_r[a]);
      if (pos[a] == '0) begin
        hi = nxt[a];
        lo = in_data.center_sample;
        half_nxt[a] = 1'b0;
      end else if (n != 32'd0 && 32'(pos[a]) == n - 32'd1) begin
        hi = in_data.center_sample;
        lo = prv[a];
        half_nxt[a] = 1'b0;
      end else begin
        hi = nxt[a];
        lo = prv[a];
        half_nxt[a] = 1'b1;
      end
      mag_nxt[a] = (hi >= lo) ? hi - lo : lo - hi;
    end
  end

  logic                v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [SAMPLE_W-1:0] mag_r  [3];
  logic                half1_r [3];
  logic [PROD_W-1:0]   prod_r [3];
  logic                half2_r [3];
  logic [2*HALF_W-1:0] phh_r [3];
  logic [2*HALF_W-1:0] phl_r [3];
  logic [2*HALF_W-1:0] pll_r [3];
  logic [SQ_W-1:0]     sq_r  [3];
  logic [SUM_W-1:0]    sum_r;

  // Advance the valid bits of the arithmetic stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [DERIV_W-1:0] g;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        // Stage 1: magnitude and rule
        mag_r[a]   <= mag_nxt[a];
        half1_r[a] <= half_nxt[a];
        // Stage 2: scale by the reciprocal spacing
        prod_r[a]  <= PROD_W'(mag_r[a]) * PROD_W'(inv_r[a]);
        half2_r[a] <= half1_r[a];
        // Stage 3: truncate to Q16.24 and square in halves
        g = half2_r[a] ? DERIV_W'(prod_r[a] >> 25) : DERIV_W'(prod_r[a] >> 24);
        phh_r[a] <= (2*HALF_W)'(g[DERIV_W-1:HALF_W]) * (2*HALF_W)'(g[DERIV_W-1:HALF_W]);
        phl_r[a] <= (2*HALF_W)'(g[DERIV_W-1:HALF_W]) * (2*HALF_W)'(g[HALF_W-1:0]);
        pll_r[a] <= (2*HALF_W)'(g[HALF_W-1:0]) * (2*HALF_W)'(g[HALF_W-1:0]);
        // Stage 4: recombine each square
        sq_r[a] <= (SQ_W'(phh_r[a]) << (2*HALF_W)) + (SQ_W'(phl_r[a]) << (HALF_W+1))
                   + SQ_W'(pll_r[a]);
      end
      // Stage 5: sum the three squares exactly
      sum_r <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    end
  end

  // Square root, one bit per stage
  logic              root_valid;
  logic [ROOT_W-1:0] root;

  ggm_sqrt_pipe #(
    .RAD_W  (SUM_W),
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .in_rad    (sum_r),
    .out_valid (root_valid),
    .out_root  (root)
  );

  // The sum stays below 2^82, so the root never reaches the 48-bit limit
  assign out_valid              = root_valid;
  assign out_data.gradient_norm = NORM_W'(root);
  assign out_data.saturated     = 1'b0;

endmodule

>>> sv/ggm_checker.sv
// Port-level checker for the gradient magnitude block, bound to the top.
// Depends on ggm_pkg and grid_gradient_magnitude_macros.svh.
`include "grid_gradient_magnitude_macros.svh"

module ggm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input ggm_pkg::out_t out_data
);
  import ggm_pkg::*;

  // Hold a stalled result beat
  `GGM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")

  // Take input whenever the output side is free
  `GGM_ASSERT_IMPL(a_in_free, clk, rst_n, !(out_valid && out_stall), !in_stall, "input stalled with free output")

  // Never flag saturation at these widths
  `GGM_ASSERT_IMPL(a_no_sat, clk, rst_n, out_valid, !out_data.saturated, "magnitude saturated")

  // Drop all results across reset
  `GGM_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind grid_gradient_magnitude ggm_checker u_ggm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> verif/grid_gradient_magnitude_tb.sv
// Self-checking testbench for grid_gradient_magnitude: random points with gaps and stalls,
// checked in order against a fixed-point gradient-magnitude predictor.
// Depends on ggm_pkg and the grid_gradient_magnitude RTL.
module grid_gradient_magnitude_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ggm_pkg::*;

  localparam int GRID_LIMIT = 1024;
  localparam int PIPE_DRAIN = 60;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic [SIZE_W-1:0] size_x = 11'd2, size_y = 11'd2, size_z = 11'd2;
  logic [SAMPLE_W-1:0] rate_x = 32'h0100_0000, rate_y = 32'h0100_0000, rate_z = 32'h0100_0000;

  in_t point_q[$];
  out_t norm_q[$];
  int in_gap = 0;
  int out_gap = 0;
  bit quiet = 1'b0;
  int mismatches = 0;

  grid_gradient_magnitude i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Mostly short gaps, a few long ones, none in quiet stretches.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One axis: edge-dependent difference scaled by the reciprocal spacing.
  function automatic logic [39:0] axis_slope(logic [31:0] c, logic [31:0] p, logic [31:0] n,
                                             logic [9:0] pos, logic [10:0] size,
                                             logic [31:0] rate);
    logic [10:0] lim;
    logic [31:0] hi, lo, mag;
    logic [63:0] prod;
    lim = (size > GRID_LIMIT) ? 11'(GRID_LIMIT) : size;
    if (pos == 0) begin
      hi = n; lo = c;
      mag = (hi >= lo) ? hi - lo : lo - hi;
      prod = {32'b0, mag} * {32'b0, rate};
      return prod[63:24];
    end else if (lim > 0 && {1'b0, pos} == lim - 11'd1) begin
      hi = c; lo = p;
      mag = (hi >= lo) ? hi - lo : lo - hi;
      prod = {32'b0, mag} * {32'b0, rate};
      return prod[63:24];
    end
    mag = (n >= p) ? n - p : p - n;
    prod = {32'b0, mag} * {32'b0, rate};
    return {1'b0, prod[63:25]};
  endfunction

  // Magnitude: floor square root of the summed squares.
  function automatic out_t grad_norm(in_t d);
    logic [39:0] gx, gy, gz;
    logic [95:0] sum, sq;
    logic [47:0] r, t;
    out_t o;
    gx = axis_slope(d.center_sample, d.x_prev_sample, d.x_next_sample, d.x_pos, size_x, rate_x);
    gy = axis_slope(d.center_sample, d.y_prev_sample, d.y_next_sample, d.y_pos, size_y, rate_y);
    gz = axis_slope(d.center_sample, d.z_prev_sample, d.z_next_sample, d.z_pos, size_z, rate_z);
    sum = {56'b0, gx} * {56'b0, gx} + {56'b0, gy} * {56'b0, gy} + {56'b0, gz} * {56'b0, gz};
    r = '0;
    for (int b = 47; b >= 0; b--) begin
      t = r | (48'd1 << b);
      sq = {48'b0, t} * {48'b0, t};
      if (sq <= sum) r = t;
    end
    // Three squares of 40-bit slopes stay far below 2^96, so no clipping
    o.gradient_norm = r;
    o.saturated = 1'b0;
    return o;
  endfunction

  // Driver: advance to the next point once the current beat is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) norm_q.push_back(grad_norm(in_data));
      if (in_valid && in_stall) begin
        // hold the stalled beat
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (point_q.size() > 0) begin
        in_data <= point_q.pop_front();
        in_valid <= 1'b1;
        in_gap = gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random stall, check each taken beat against the oldest expectation.
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (norm_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat: %h", out_data);
        end else begin
          want = norm_q.pop_front();
          if (out_data.gradient_norm !== want.gradient_norm ||
              out_data.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: norm exp %h got %h, sat exp %b got %b",
                       want.gradient_norm, out_data.gradient_norm,
                       want.saturated, out_data.saturated);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = gap_len();
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_X_SIZE:     size_x = val[10:0];
      REG_Y_SIZE:     size_y = val[10:0];
      REG_Z_SIZE:     size_z = val[10:0];
      REG_INV_STEP_X: rate_x = val;
      REG_INV_STEP_Y: rate_y = val;
      REG_INV_STEP_Z: rate_z = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                          logic [31:0] rx, logic [31:0] ry, logic [31:0] rz);
    write_reg(REG_X_SIZE, sx);
    write_reg(REG_Y_SIZE, sy);
    write_reg(REG_Z_SIZE, sz);
    write_reg(REG_INV_STEP_X, rx);
    write_reg(REG_INV_STEP_Y, ry);
    write_reg(REG_INV_STEP_Z, rz);
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000 + $urandom_range(255) - 128;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [9:0] pick_pos(logic [10:0] size);
    logic [10:0] top;
    top = (size > GRID_LIMIT) ? 11'(GRID_LIMIT) : size;
    case ($urandom_range(3))
      0: return '0;
      1: return 10'(top - 11'd1);
      2: return (top > 1) ? 10'($urandom_range(top - 1)) : '0;
      default: return 10'($urandom());
    endcase
  endfunction

  function automatic in_t rand_point();
    in_t p;
    p.center_sample = pick_sample();
    p.x_prev_sample = pick_sample();
    p.x_next_sample = pick_sample();
    p.y_prev_sample = pick_sample();
    p.y_next_sample = pick_sample();
    p.z_prev_sample = pick_sample();
    p.z_next_sample = pick_sample();
    p.x_pos = pick_pos(size_x);
    p.y_pos = pick_pos(size_y);
    p.z_pos = pick_pos(size_z);
    return p;
  endfunction

  function automatic in_t flat_point(logic [31:0] c, logic [31:0] nb, logic [9:0] x,
                                     logic [9:0] y, logic [9:0] z);
    in_t p;
    p = '{c, nb, nb, nb, nb, nb, nb, x, y, z};
    return p;
  endfunction

  // Wait for the pipeline to empty before touching the registers.
  task automatic drain();
    while (point_q.size() > 0 || in_valid || norm_q.size() > 0) @(posedge clk);
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic random_points(int n);
    repeat (n) point_q.push_back(rand_point());
    drain();
  endtask

  initial begin
    in_t p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points under reset settings: both edges and positions beyond the last point.
    point_q.push_back(flat_point('0, '0, 10'd0, 10'd0, 10'd0));
    point_q.push_back(flat_point('1, '1, 10'd1, 10'd1, 10'd1));
    point_q.push_back(flat_point('1, '0, 10'd0, 10'd1, 10'd0));
    point_q.push_back(flat_point('0, '1, 10'd1, 10'd0, 10'd1));
    point_q.push_back(flat_point(32'h1234_5678, '1, 10'd1023, 10'd5, 10'd2));
    p = '{'1, '0, '1, '1, '0, '0, '1, 10'd0, 10'd1, 10'd1023};
    point_q.push_back(p);
    p = '{'0, '1, '0, '0, '1, '1, '0, 10'd2, 10'd0, 10'd1};
    point_q.push_back(p);
    drain();

    // Largest grid, largest spacing reciprocals.
    set_grid(32'd1024, 32'd1024, 32'd1024, '1, '1, '1);
    write_reg(REG_SPARE_A, $urandom());
    point_q.push_back(flat_point('1, '0, 10'd0, 10'd1023, 10'd512));
    p = '{'0, '0, '1, '1, '0, '0, '1, 10'd512, 10'd512, 10'd512};
    point_q.push_back(p);
    p = '{'0, '1, '0, '0, '1, '1, '0, 10'd1023, 10'd1023, 10'd1023};
    point_q.push_back(p);
    random_points(300);

    // Degenerate sizes and a zero spacing reciprocal.
    set_grid(32'd0, 32'd1, 32'hFFFF_F801, '0, 32'h0000_0001, 32'h0080_0000);
    write_reg(REG_SPARE_B, $urandom());
    point_q.push_back(flat_point('1, '0, 10'd0, 10'd0, 10'd0));
    point_q.push_back(flat_point('1, '0, 10'd1023, 10'd1023, 10'd1023));
    random_points(250);

    // Oversized grid clamps to the maximum; run without idling.
    quiet = 1'b1;
    set_grid(32'd2047, 32'd1025, 32'd1023, $urandom(), $urandom(), $urandom());
    random_points(300);
    quiet = 1'b0;

    // Small random grids and spacings.
    repeat (5) begin
      set_grid($urandom_range(2, 12), $urandom_range(2, 12), $urandom_range(2, 40),
               $urandom(), $urandom_range(32'h0200_0000), $urandom());
      random_points(200);
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
